// ----- design/ctd_pkg.sv -----
// Shared types and constants of the cooperative task dispatcher.
// Used by the controller, the datapath and the top level; depends on nothing.
package ctd_pkg;

    localparam int MAX_TASKS_DEF = 8;

    localparam int MODE_W  = 3;
    localparam int ID_W    = 8;
    localparam int DELAY_W = 16;
    localparam int STEP_W  = 8;
    localparam int SLOT_W  = 3;

    localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELAY    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_STEP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DISP,
        ST_MOD,
        ST_TICK,
        ST_DONE
    } ctd_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REG,
        OP_DISP_SEL,
        OP_DISP_FIN,
        OP_RD_CUR,
        OP_MOD,
        OP_TICK_START,
        OP_TICK_STEP,
        OP_EMIT
    } ctd_op_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              empty;
        logic              tick_last;
        logic              out_free;
    } ctd_status_t;

    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic               waiting;
        logic [DELAY_W-1:0] delay;
        logic [STEP_W-1:0]  step;
    } ctd_entry_t;

    localparam int ENTRY_W = $bits(ctd_entry_t);

endpackage

// ----- design/ctd_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; depends on nothing.
module ctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/ctd_ctrl.sv -----
// Controller state machine of the task dispatcher.
// Issues one datapath command per cycle; depends on ctd_pkg.
module ctd_ctrl
    import ctd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ctd_status_t status,
    output ctd_op_t     op
);

    ctd_state_t state_reg;
    ctd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (status.mode)
                    MODE_REGISTER:
                    begin
                        op         = OP_REG;
                        state_next = ST_DONE;
                    end
                    MODE_DISPATCH:
                    begin
                        if (status.empty)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            op         = OP_DISP_SEL;
                            state_next = ST_DISP;
                        end
                    end
                    MODE_DELAY, MODE_SET_STEP:
                    begin
                        op         = OP_RD_CUR;
                        state_next = ST_MOD;
                    end
                    MODE_TICK:
                    begin
                        if (status.empty)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            op         = OP_TICK_START;
                            state_next = ST_TICK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DISP:
            begin
                op         = OP_DISP_FIN;
                state_next = ST_DONE;
            end
            ST_MOD:
            begin
                op         = OP_MOD;
                state_next = ST_DONE;
            end
            ST_TICK:
            begin
                op = OP_TICK_STEP;
                if (status.tick_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ctd_datapath.sv -----
// Datapath of the task dispatcher: slot table RAM, counters and result registers.
// Driven by ctd_ctrl commands; depends on ctd_pkg and ctd_ram.
module ctd_datapath
    import ctd_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctd_op_t            op,
    output ctd_status_t        status,
    input  logic [MODE_W-1:0]  mode,
    input  logic [ID_W-1:0]    task_id,
    input  logic [DELAY_W-1:0] delay_ms,
    input  logic [STEP_W-1:0]  step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic               run_now,
    output logic               run_kind,
    output logic [SLOT_W-1:0]  slot,
    output logic [ID_W-1:0]    run_task_id,
    output logic [STEP_W-1:0]  run_step
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic [MODE_W-1:0]  mode_reg;
    logic [ID_W-1:0]    tid_reg;
    logic [DELAY_W-1:0] dly_reg;
    logic [STEP_W-1:0]  stp_reg;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] nxt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;

    logic              res_acc_reg;
    logic              res_run_reg;
    logic              res_kind_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic [STEP_W-1:0] res_step_reg;

    logic              out_acc_reg;
    logic              out_run_reg;
    logic              out_kind_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [STEP_W-1:0] out_step_reg;

    logic             full;
    logic             empty;
    logic [IDX_W-1:0] sel;
    logic [CNT_W-1:0] sel_inc;
    logic             sel_wrap;
    logic [CNT_W-1:0] idx_inc;
    logic             tick_last;
    logic             expired;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    ctd_entry_t       rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ctd_entry_t       wr_data;

    ctd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign full      = (count_reg == CNT_W'(MAX_TASKS));
    assign empty     = (count_reg == '0);
    assign sel       = (CNT_W'(nxt_reg) >= count_reg) ? '0 : nxt_reg;
    assign sel_inc   = CNT_W'(sel) + 1'b1;
    assign sel_wrap  = (sel_inc >= count_reg);
    assign idx_inc   = CNT_W'(idx_reg) + 1'b1;
    assign tick_last = (idx_inc >= count_reg);
    assign expired   = rd_data.waiting && (rd_data.delay == '0);

    assign status.mode      = mode_reg;
    assign status.empty     = empty;
    assign status.tick_last = tick_last;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data;
        case (op)
            OP_REG:
            begin
                wr_en           = !full;
                wr_addr         = count_reg[IDX_W-1:0];
                wr_data.task_id = tid_reg;
                wr_data.waiting = 1'b0;
                wr_data.delay   = '0;
                wr_data.step    = '0;
            end
            OP_DISP_SEL:
            begin
                rd_en   = 1'b1;
                rd_addr = sel;
            end
            OP_DISP_FIN:
            begin
                wr_en           = expired;
                wr_addr         = cur_reg;
                wr_data.waiting = 1'b0;
            end
            OP_RD_CUR:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg;
            end
            OP_MOD:
            begin
                wr_en        = 1'b1;
                wr_addr      = cur_reg;
                wr_data.step = stp_reg;
                if (mode_reg == MODE_DELAY)
                begin
                    wr_data.delay   = dly_reg;
                    wr_data.waiting = 1'b1;
                end
            end
            OP_TICK_START:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_TICK_STEP:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (rd_data.waiting && (rd_data.delay != '0))
                begin
                    wr_data.delay = rd_data.delay - 1'b1;
                end
                rd_en   = !tick_last;
                rd_addr = idx_inc[IDX_W-1:0];
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_reg       <= '0;
            nxt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (op)
                OP_REG:
                begin
                    if (!full)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_DISP_SEL:
                begin
                    cur_reg <= sel;
                    nxt_reg <= sel_wrap ? '0 : sel_inc[IDX_W-1:0];
                end
                OP_TICK_START:
                begin
                    idx_reg <= '0;
                end
                OP_TICK_STEP:
                begin
                    idx_reg <= idx_inc[IDX_W-1:0];
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
            if (op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                mode_reg     <= mode;
                tid_reg      <= task_id;
                dly_reg      <= delay_ms;
                stp_reg      <= step;
                res_acc_reg  <= 1'b1;
                res_run_reg  <= 1'b0;
                res_kind_reg <= 1'b0;
                res_slot_reg <= '0;
                res_id_reg   <= '0;
                res_step_reg <= '0;
            end
            OP_REG:
            begin
                res_acc_reg <= !full;
            end
            OP_DISP_SEL:
            begin
                res_slot_reg <= SLOT_W'(sel);
            end
            OP_DISP_FIN:
            begin
                res_id_reg   <= rd_data.task_id;
                res_step_reg <= rd_data.step;
                res_run_reg  <= !rd_data.waiting || expired;
                res_kind_reg <= expired;
            end
            OP_EMIT:
            begin
                out_acc_reg  <= res_acc_reg;
                out_run_reg  <= res_run_reg;
                out_kind_reg <= res_kind_reg;
                out_slot_reg <= res_slot_reg;
                out_id_reg   <= res_id_reg;
                out_step_reg <= res_step_reg;
            end
            default:
            begin
                res_acc_reg <= res_acc_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = out_acc_reg;
    assign run_now     = out_run_reg;
    assign run_kind    = out_kind_reg;
    assign slot        = out_slot_reg;
    assign run_task_id = out_id_reg;
    assign run_step    = out_step_reg;

endmodule

// ----- design/coop_task_dispatcher_with_delays.sv -----
// Top level of the cooperative round-robin task dispatcher with delays.
// Joins ctd_ctrl and ctd_datapath; depends on ctd_pkg.
//
// Usage: each item on the s_axis channel is one event, selected by tuser
// (register task, dispatch next, delay current, set step, tick). Each event
// gives exactly one result item on the m_axis channel.
// Timing: s_axis_tready is high only while the block is idle; one event is
// worked on at a time. Register, unknown events and a dispatch on an empty
// table go straight to the output register; other dispatches, delay and set
// step first read the slot and then finish or write it back, and a tick
// walks the slot table RAM one slot per cycle over its single write port. The
// next event can be taken in the cycle after the result is registered.
// The output register frees the input side: a new event is accepted while
// a finished result still waits for m_axis_tready. A second result waits in
// the controller until the output register is free.
// Reset clears the task count, the round-robin pointers, the controller
// and the output valid flag. The slot table needs no clearing pass, since
// registering a task writes every field of its slot.
module coop_task_dispatcher_with_delays
    import ctd_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // task_id[7:0], delay_ms[23:8], step[31:24]
    input  logic [2:0]  s_axis_tuser,  // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // accepted[0], run_now[1], slot[4:2],
                                       // run_task_id[12:5], run_step[20:13], zero[23:21]
    output logic [0:0]  m_axis_tuser   // run_kind[0]
);

    ctd_op_t     op;
    ctd_status_t status;

    logic              accepted;
    logic              run_now;
    logic              run_kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   run_task_id;
    logic [STEP_W-1:0] run_step;

    ctd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .op       (op)
    );

    ctd_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .status      (status),
        .mode        (s_axis_tuser),
        .task_id     (s_axis_tdata[7:0]),
        .delay_ms    (s_axis_tdata[23:8]),
        .step        (s_axis_tdata[31:24]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .accepted    (accepted),
        .run_now     (run_now),
        .run_kind    (run_kind),
        .slot        (slot),
        .run_task_id (run_task_id),
        .run_step    (run_step)
    );

    assign m_axis_tdata = {3'b000, run_step, run_task_id, slot, run_now, accepted};
    assign m_axis_tuser = run_kind;

endmodule

// ----- design/ctd_checker.sv -----
// Port-level checker for the task dispatcher, bound to the top level.
// Depends only on the top level's ports.
module ctd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // Only one event is in work, so the input side closes after an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready stayed high after an item was taken");

    // A run after delay expiry is always a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata[1])
    else $error("run_kind set without run_now");

    // A refused registration carries no run information.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |->
            (m_axis_tdata[23:1] == 23'd0 && !m_axis_tuser[0]))
    else $error("refused item carries run fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result item changed or was dropped");

endmodule

bind coop_task_dispatcher_with_delays ctd_checker u_ctd_checker (.*);

// ----- tb/sv/coop_task_dispatcher_with_delays_tb.sv -----
// Self-checking testbench of the cooperative round-robin task dispatcher.
// Drives event items with random gaps and back-pressure and checks every result
// against a scoreboard that tracks the slot table; depends on ctd_pkg and the RTL.
module coop_task_dispatcher_with_delays_tb;
    import ctd_pkg::*;

    typedef struct packed {
        logic       accepted;
        logic       run_now;
        logic       run_kind;
        logic [2:0] slot;
        logic [7:0] run_id;
        logic [7:0] run_step;
    } run_result_t;

    class dispatch_scoreboard;
        logic [7:0]  ids[MAX_TASKS_DEF];
        logic        waiting[MAX_TASKS_DEF];
        logic [15:0] delays[MAX_TASKS_DEF];
        logic [7:0]  steps[MAX_TASKS_DEF];
        int          task_count;
        int          cur_slot;
        int          nxt_slot;
        run_result_t expected_runs[$];
        int          errors;

        function new();
            task_count = 0;
            cur_slot = 0;
            nxt_slot = 0;
            errors = 0;
        endfunction

        function void predict_event(logic [2:0] mode, logic [7:0] id, logic [15:0] dly,
                                    logic [7:0] stp);
            run_result_t r;
            int s;
            r = '0;
            r.accepted = 1'b1;
            case (mode)
                MODE_REGISTER:
                begin
                    if (task_count >= MAX_TASKS_DEF)
                    begin
                        r.accepted = 1'b0;
                    end
                    else
                    begin
                        ids[task_count] = id;
                        waiting[task_count] = 1'b0;
                        delays[task_count] = '0;
                        steps[task_count] = '0;
                        task_count++;
                    end
                end
                MODE_DISPATCH:
                begin
                    if (task_count > 0)
                    begin
                        s = (nxt_slot >= task_count) ? 0 : nxt_slot;
                        cur_slot = s;
                        nxt_slot = (s + 1 >= task_count) ? 0 : s + 1;
                        r.slot = s[2:0];
                        r.run_id = ids[s];
                        r.run_step = steps[s];
                        if (!waiting[s])
                        begin
                            r.run_now = 1'b1;
                        end
                        else if (delays[s] == '0)
                        begin
                            waiting[s] = 1'b0;
                            r.run_now = 1'b1;
                            r.run_kind = 1'b1;
                        end
                    end
                end
                MODE_DELAY:
                begin
                    delays[cur_slot] = dly;
                    waiting[cur_slot] = 1'b1;
                    steps[cur_slot] = stp;
                end
                MODE_SET_STEP:
                begin
                    steps[cur_slot] = stp;
                end
                MODE_TICK:
                begin
                    for (int i = 0; i < task_count; i++)
                    begin
                        if (waiting[i] && delays[i] != '0)
                        begin
                            delays[i] = delays[i] - 16'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            expected_runs.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch in %s: expected %0h, got %0h", name, want, got);
                end
            end
        endfunction

        function void check_run(logic [23:0] data, logic [0:0] user);
            run_result_t want;
            if (expected_runs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result item: data %0h, user %0h", data, user);
                end
                return;
            end
            want = expected_runs.pop_front();
            compare_field("accepted", 8'(want.accepted), 8'(data[0]));
            compare_field("run_now", 8'(want.run_now), 8'(data[1]));
            compare_field("slot", 8'(want.slot), 8'(data[4:2]));
            compare_field("run_task_id", want.run_id, data[12:5]);
            compare_field("run_step", want.run_step, data[20:13]);
            compare_field("padding", 8'd0, 8'(data[23:21]));
            compare_field("run_kind", 8'(want.run_kind), 8'(user[0]));
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction

        function int failures();
            return errors + expected_runs.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    bit steady = 1'b0;
    dispatch_scoreboard sb = new();

    coop_task_dispatcher_with_delays uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_run(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_event(input logic [2:0] mode, input logic [7:0] id,
                              input logic [15:0] dly, input logic [7:0] stp);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {stp, dly, id};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.predict_event(mode, id, dly, stp);
        @(negedge clk);
    endtask

    task automatic send_random_event(output bit counted);
        int unsigned pick;
        logic [2:0]  mode;
        logic [15:0] dly;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            mode = MODE_REGISTER;
        else if (pick < 40)
            mode = MODE_DISPATCH;
        else if (pick < 55)
            mode = MODE_DELAY;
        else if (pick < 65)
            mode = MODE_SET_STEP;
        else if (pick < 94)
            mode = MODE_TICK;
        else
            mode = MODE_TICK + 3'($urandom_range(1, 3));
        dly = 16'($urandom_range(0, 16'hFFFF));
        if (mode == MODE_DELAY)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                dly = 16'($urandom_range(0, 4));
            else if (pick < 9)
                dly = 16'($urandom_range(0, 40));
        end
        counted = (mode <= MODE_TICK);
        send_event(mode, 8'($urandom_range(0, 255)), dly, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        int sent;
        bit counted;
        bit paused;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table, writes to the current slot before any task exists, unused modes.
        send_event(MODE_DISPATCH, 8'hFF, 16'hFFFF, 8'hFF);
        send_event(MODE_TICK, 8'hFF, 16'hFFFF, 8'hFF);
        send_event(MODE_SET_STEP, 8'h00, 16'h0000, 8'hFF);
        send_event(MODE_DELAY, 8'h00, 16'hFFFF, 8'hAA);
        send_event(MODE_TICK + 3'd1, 8'hFF, 16'hFFFF, 8'hFF);
        send_event(MODE_TICK + 3'd2, 8'hFF, 16'hFFFF, 8'hFF);
        send_event(MODE_TICK + 3'd3, 8'hFF, 16'hFFFF, 8'hFF);
        send_event(MODE_REGISTER, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_REGISTER, 8'hFF, 16'hFFFF, 8'hFF);
        send_event(MODE_REGISTER, 8'h5A, 16'h1234, 8'h77);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_SET_STEP, 8'h00, 16'h0000, 8'hFF);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        // A waiting slot with no delay left runs as an expired delay.
        send_event(MODE_DELAY, 8'h00, 16'h0000, 8'h33);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_DELAY, 8'h00, 16'h0002, 8'h01);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_TICK, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_TICK, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_TICK, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_DISPATCH, 8'h00, 16'h0000, 8'h00);
        send_event(MODE_DELAY, 8'h00, 16'hFFFF, 8'h00);
        wait_drained();

        sent = 0;
        paused = 1'b0;
        while (sent < 1500)
        begin
            steady = (sent >= 700 && sent < 900);
            if (sent == 400 && !paused)
            begin
                paused = 1'b1;
                wait_drained();
            end
            send_random_event(counted);
            if (counted)
                sent++;
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.failures() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end
endmodule
